### sv/arp_pkg.sv
package arp_pkg;

    localparam int MAX_HELD_DEF    = 16;
    localparam int MAX_PATTERN_DEF = 32;
    localparam int MAX_STRUM_DEF   = 16;

    localparam int TW          = 13;
    localparam int RECIP_SHIFT = 28;

    localparam logic [7:0]  NO_NOTE     = 8'd255;
    localparam logic [7:0]  OCT_STEP    = 8'd12;
    localparam logic [15:0] LFSR_SEED   = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS   = 16'hB400;
    localparam logic [20:0] SWING_RECIP = 21'd1056833;
    localparam logic [21:0] GATE_RECIP  = 22'd2113666;

    localparam logic [2:0] OP_TICK         = 3'd0;
    localparam logic [2:0] OP_NOTE_ON      = 3'd1;
    localparam logic [2:0] OP_NOTE_OFF     = 3'd2;
    localparam logic [2:0] OP_CLEAR_HOLD   = 3'd3;
    localparam logic [2:0] OP_CAPTURE_HOLD = 3'd4;

    localparam logic [1:0] EV_NOTE_ON  = 2'd0;
    localparam logic [1:0] EV_NOTE_OFF = 2'd1;
    localparam logic [1:0] EV_ALL_OFF  = 2'd2;

    localparam logic [2:0] REG_ENABLED   = 3'd0;
    localparam logic [2:0] REG_HOLD      = 3'd1;
    localparam logic [2:0] REG_STRUM     = 3'd2;
    localparam logic [2:0] REG_PATTERN   = 3'd3;
    localparam logic [2:0] REG_OCTAVES   = 3'd4;
    localparam logic [2:0] REG_GATE      = 3'd5;
    localparam logic [2:0] REG_SWING     = 3'd6;
    localparam logic [2:0] REG_STEP_BASE = 3'd7;

    localparam logic [1:0] MODE_UP   = 2'd0;
    localparam logic [1:0] MODE_DOWN = 2'd1;
    localparam logic [1:0] MODE_PING = 2'd2;

    typedef enum logic [2:0] {
        CMD_TICK, CMD_ON, CMD_OFF, CMD_CLR, CMD_CAP, CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [6:0] note;
        logic [6:0] vel;
    } cmd_t;

    typedef struct packed {
        logic       last;
        logic [6:0] vel;
        logic [7:0] note;
        logic [1:0] kind;
    } evt_t;

endpackage

### sv/arp_fifo.sv
module arp_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             nonempty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    assign full     = cnt_reg == 2'd2;
    assign nonempty = cnt_reg != 2'd0;
    assign rdata    = mem_reg[rptr_reg];

endmodule

### sv/arp_front.sv
module arp_front import arp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [2:0]  s_tuser,
    output logic        cmd_valid,
    input  logic        cmd_pop,
    output cmd_t        cmd
);

    cmd_t       in_cmd;
    logic       full;
    logic [$bits(cmd_t)-1:0] rdata;

    always_comb begin
        in_cmd.note = s_tdata[6:0];
        in_cmd.vel  = s_tdata[13:7];
        case (s_tuser)
            OP_TICK:         in_cmd.kind = CMD_TICK;
            OP_NOTE_ON:      in_cmd.kind = CMD_ON;
            OP_NOTE_OFF:     in_cmd.kind = CMD_OFF;
            OP_CLEAR_HOLD:   in_cmd.kind = CMD_CLR;
            OP_CAPTURE_HOLD: in_cmd.kind = CMD_CAP;
            default:         in_cmd.kind = CMD_NOP;
        endcase
    end

    assign s_tready = !full;

    arp_fifo #(.WIDTH($bits(cmd_t))) u_cmd_q (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_tvalid && !full),
        .wdata    (in_cmd),
        .full     (full),
        .pop      (cmd_pop),
        .rdata    (rdata),
        .nonempty (cmd_valid)
    );

    assign cmd = cmd_t'(rdata);

endmodule

### sv/arp_back.sv
module arp_back import arp_pkg::*; #(
    parameter int MAX_HELD    = MAX_HELD_DEF,
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int MAX_STRUM   = MAX_STRUM_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        cmd_valid,
    output logic        cmd_pop,
    input  cmd_t        cmd,
    output logic        evt_push,
    output evt_t        evt,
    input  logic        evt_full
);

    localparam int HCW = $clog2(MAX_HELD + 1);
    localparam int HIW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
    localparam int SCW = $clog2(MAX_STRUM + 1);
    localparam int SIW = (MAX_STRUM > 1) ? $clog2(MAX_STRUM) : 1;
    localparam int LW  = $clog2(MAX_PATTERN + 1);
    localparam int PW  = $clog2(MAX_PATTERN);
    localparam int IXW = (HCW > SCW) ? HCW : SCW;

    typedef enum logic [26:0] {
        S_IDLE      = 27'd1 << 0,
        S_TK0       = 27'd1 << 1,
        S_TK1       = 27'd1 << 2,
        S_TK2       = 27'd1 << 3,
        S_TK3       = 27'd1 << 4,
        S_ON0       = 27'd1 << 5,
        S_ON_SRCH   = 27'd1 << 6,
        S_ON_LATCH  = 27'd1 << 7,
        S_COPY      = 27'd1 << 8,
        S_ON_EN     = 27'd1 << 9,
        S_ON_PLAY   = 27'd1 << 10,
        S_ON_PLAY2  = 27'd1 << 11,
        S_OFF_SRCH  = 27'd1 << 12,
        S_OFF_SHIFT = 27'd1 << 13,
        S_OFF_POST  = 27'd1 << 14,
        S_OFF_STRUM = 27'd1 << 15,
        S_OFF_ALL   = 27'd1 << 16,
        S_BUILD     = 27'd1 << 17,
        S_LEN_MUL   = 27'd1 << 18,
        S_LEN_DIV   = 27'd1 << 19,
        S_LEN_FIN   = 27'd1 << 20,
        S_G_MUL     = 27'd1 << 21,
        S_G_DIV     = 27'd1 << 22,
        S_G_FIN     = 27'd1 << 23,
        S_NXT       = 27'd1 << 24,
        S_MOD       = 27'd1 << 25,
        S_FIN       = 27'd1 << 26
    } state_t;

    logic        en_reg, hold_reg, strum_reg;
    logic [1:0]  mode_reg;
    logic [2:0]  span_reg;
    logic [6:0]  gate_reg, swing_reg;
    logic [11:0] base_reg;

    logic [6:0] held_key_reg [MAX_HELD];
    logic [6:0] held_vel_reg [MAX_HELD];
    logic [6:0] lat_key_reg  [MAX_HELD];
    logic [6:0] lat_vel_reg  [MAX_HELD];
    logic [7:0] pat_note_reg [MAX_PATTERN];
    logic [6:0] pat_vel_reg  [MAX_PATTERN];
    logic [6:0] strum_key_reg[MAX_STRUM];

    state_t     state_reg, state_next, ret_reg, ret_next;
    cmd_t       cmd_reg, cmd_next;
    logic [IXW-1:0] idx_reg, idx_next;
    logic [HIW-1:0] bi_reg, bi_next;
    logic [2:0]     boct_reg, boct_next;
    logic [7:0]     boff_reg, boff_next;
    logic [HCW-1:0] hcnt_reg, hcnt_next, lcnt_reg, lcnt_next;
    logic [SCW-1:0] scnt_reg, scnt_next;
    logic [LW-1:0]  plen_reg, plen_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic           down_reg, down_next;
    logic [TW-1:0]  ticks_reg, ticks_next, gr_reg, gr_next, len_reg, len_next;
    logic [TW-1:0]  quo_reg, quo_next;
    logic [19:0]    prod_reg, prod_next;
    logic [7:0]     sn_reg, sn_next;
    logic [15:0]    lfsr_reg, lfsr_next, divd_reg, divd_next;
    logic           floor_reg, floor_next;
    logic [3:0]     modcnt_reg, modcnt_next;
    logic [LW-1:0]  rem_reg, rem_next;
    evt_t           pend_reg, pend_next;
    logic           pend_vld_reg, pend_vld_next;

    logic           go;
    logic           emit_req;
    evt_t           emit_evt;
    logic           h_we, l_we, p_we, s_we;
    logic [HIW-1:0] h_waddr, h_raddr, l_waddr;
    logic [6:0]     h_wkey, h_wvel, h_rkey, h_rvel, s_rkey;
    logic [PW-1:0]  p_waddr;
    logic [7:0]     p_wnote, p_rnote;
    logic [6:0]     p_wvel, p_rvel;
    logic [SIW-1:0] s_waddr;
    logic [HCW-1:0] act_cnt;
    logic [41:0]    wide;
    logic [11:0]    amt;
    logic [TW-1:0]  g;
    logic [LW:0]    r2;
    logic [LW-1:0]  p1;
    logic [15:0]    lf;

    assign go        = !pend_vld_reg || !evt_full;
    assign cfg_ready = 1'b1;
    assign act_cnt   = hold_reg ? lcnt_reg : hcnt_reg;
    assign cmd_pop   = go && (state_reg == S_IDLE) && cmd_valid;

    always_comb begin
        case (state_reg)
            S_OFF_SHIFT: h_raddr = HIW'(idx_reg + IXW'(1));
            S_BUILD:     h_raddr = bi_reg;
            default:     h_raddr = HIW'(idx_reg);
        endcase
    end

    assign h_rkey  = held_key_reg[h_raddr];
    assign h_rvel  = held_vel_reg[h_raddr];
    assign p_rnote = pat_note_reg[pos_reg];
    assign p_rvel  = pat_vel_reg[pos_reg];
    assign s_rkey  = strum_key_reg[SIW'(idx_reg)];

    always_comb begin
        state_next = state_reg;  ret_next = ret_reg;  cmd_next = cmd_reg;
        idx_next = idx_reg;  bi_next = bi_reg;  boct_next = boct_reg;  boff_next = boff_reg;
        hcnt_next = hcnt_reg;  lcnt_next = lcnt_reg;  scnt_next = scnt_reg;
        plen_next = plen_reg;  pos_next = pos_reg;  down_next = down_reg;
        ticks_next = ticks_reg;  gr_next = gr_reg;  len_next = len_reg;
        quo_next = quo_reg;  prod_next = prod_reg;  sn_next = sn_reg;
        lfsr_next = lfsr_reg;  divd_next = divd_reg;  floor_next = floor_reg;
        modcnt_next = modcnt_reg;  rem_next = rem_reg;
        pend_next = pend_reg;  pend_vld_next = pend_vld_reg;
        emit_req = 1'b0;  emit_evt = '0;
        h_we = 1'b0;  h_waddr = HIW'(idx_reg);  h_wkey = cmd_reg.note;  h_wvel = cmd_reg.vel;
        l_we = 1'b0;  l_waddr = HIW'(idx_reg);
        p_we = 1'b0;  p_waddr = PW'(plen_reg);  p_wnote = '0;  p_wvel = '0;
        s_we = 1'b0;  s_waddr = SIW'(scnt_reg);
        wide = '0;  amt = '0;  g = '0;  r2 = '0;  p1 = '0;  lf = '0;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_next = cmd;
                    idx_next = '0;
                    case (cmd.kind)
                        CMD_TICK: state_next = S_TK0;
                        CMD_ON:   state_next = S_ON0;
                        CMD_OFF:  state_next = S_OFF_SRCH;
                        CMD_CLR: begin
                            lcnt_next  = '0;
                            state_next = S_FIN;
                        end
                        CMD_CAP: begin
                            if (hcnt_reg != '0) begin
                                lcnt_next  = hcnt_reg;
                                ret_next   = S_FIN;
                                state_next = S_COPY;
                            end else begin
                                state_next = S_FIN;
                            end
                        end
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_TK0: begin
                if (!en_reg || act_cnt == '0) begin
                    state_next = S_FIN;
                end else if (plen_reg == '0) begin
                    bi_next = '0;  boct_next = '0;  boff_next = '0;
                    ret_next   = S_TK1;
                    state_next = S_BUILD;
                end else begin
                    state_next = S_TK1;
                end
            end
            S_TK1: begin
                if (plen_reg == '0) begin
                    state_next = S_FIN;
                end else begin
                    if (gr_reg != '0) begin
                        gr_next = gr_reg - TW'(1);
                        if (gr_reg == TW'(1) && sn_reg != NO_NOTE) begin
                            emit_req = 1'b1;
                            emit_evt.kind = EV_NOTE_OFF;
                            emit_evt.note = sn_reg;
                            sn_next = NO_NOTE;
                        end
                    end
                    ticks_next = ticks_reg + TW'(1);
                    ret_next   = S_TK2;
                    state_next = S_LEN_MUL;
                end
            end
            S_TK2: begin
                if (ticks_reg >= len_reg) begin
                    ticks_next = '0;
                    if (sn_reg != NO_NOTE) begin
                        emit_req = 1'b1;
                        emit_evt.kind = EV_NOTE_OFF;
                        emit_evt.note = sn_reg;
                        sn_next = NO_NOTE;
                    end
                    state_next = S_TK3;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_TK3: begin
                if (LW'(pos_reg) < plen_reg) begin
                    emit_req = 1'b1;
                    emit_evt.kind = EV_NOTE_ON;
                    emit_evt.note = p_rnote;
                    emit_evt.vel  = p_rvel;
                    sn_next    = p_rnote;
                    floor_next = 1'b1;
                    state_next = S_G_MUL;
                end else begin
                    state_next = S_NXT;
                end
            end
            S_ON0: begin
                if (hold_reg && hcnt_reg == '0) begin
                    lcnt_next = '0;
                end
                state_next = (hcnt_reg < HCW'(MAX_HELD)) ? S_ON_SRCH : S_ON_LATCH;
            end
            S_ON_SRCH: begin
                if (idx_reg == IXW'(hcnt_reg)) begin
                    h_we = 1'b1;
                    h_waddr = HIW'(hcnt_reg);
                    hcnt_next  = hcnt_reg + HCW'(1);
                    state_next = S_ON_LATCH;
                end else if (h_rkey == cmd_reg.note) begin
                    h_we = 1'b1;
                    state_next = S_ON_LATCH;
                end else begin
                    idx_next = idx_reg + IXW'(1);
                end
            end
            S_ON_LATCH: begin
                if (hold_reg) begin
                    idx_next   = '0;
                    lcnt_next  = hcnt_reg;
                    ret_next   = S_ON_EN;
                    state_next = S_COPY;
                end else begin
                    state_next = S_ON_EN;
                end
            end
            S_COPY: begin
                if (idx_reg < IXW'(hcnt_reg)) begin
                    l_we = 1'b1;
                    idx_next = idx_reg + IXW'(1);
                end else begin
                    state_next = ret_reg;
                end
            end
            S_ON_EN: begin
                if (!en_reg) begin
                    state_next = S_FIN;
                end else begin
                    if (strum_reg) begin
                        emit_req = 1'b1;
                        emit_evt.kind = EV_NOTE_ON;
                        emit_evt.note = {1'b0, cmd_reg.note};
                        emit_evt.vel  = cmd_reg.vel;
                        if (scnt_reg < SCW'(MAX_STRUM)) begin
                            s_we = 1'b1;
                            scnt_next = scnt_reg + SCW'(1);
                        end
                    end
                    plen_next = '0;  bi_next = '0;  boct_next = '0;  boff_next = '0;
                    ret_next   = S_ON_PLAY;
                    state_next = S_BUILD;
                end
            end
            S_ON_PLAY: begin
                if (plen_reg != '0) begin
                    pos_next   = '0;
                    ticks_next = '0;
                    state_next = S_ON_PLAY2;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_ON_PLAY2: begin
                emit_req = 1'b1;
                emit_evt.kind = EV_NOTE_ON;
                emit_evt.note = p_rnote;
                emit_evt.vel  = p_rvel;
                sn_next    = p_rnote;
                floor_next = 1'b0;
                ret_next   = S_G_MUL;
                state_next = S_LEN_MUL;
            end
            S_OFF_SRCH: begin
                if (idx_reg >= IXW'(hcnt_reg)) begin
                    state_next = S_OFF_POST;
                end else if (h_rkey == cmd_reg.note) begin
                    state_next = S_OFF_SHIFT;
                end else begin
                    idx_next = idx_reg + IXW'(1);
                end
            end
            S_OFF_SHIFT: begin
                if (idx_reg + IXW'(1) < IXW'(hcnt_reg)) begin
                    h_we = 1'b1;
                    h_wkey = h_rkey;
                    h_wvel = h_rvel;
                    idx_next = idx_reg + IXW'(1);
                end else begin
                    hcnt_next  = hcnt_reg - HCW'(1);
                    state_next = S_OFF_POST;
                end
            end
            S_OFF_POST: begin
                idx_next = '0;
                if (hold_reg || !en_reg) begin
                    state_next = S_FIN;
                end else if (hcnt_reg == '0) begin
                    state_next = S_OFF_STRUM;
                end else begin
                    plen_next = '0;  bi_next = '0;  boct_next = '0;  boff_next = '0;
                    ret_next   = S_FIN;
                    state_next = S_BUILD;
                end
            end
            S_OFF_STRUM: begin
                if (idx_reg < IXW'(scnt_reg)) begin
                    emit_req = 1'b1;
                    emit_evt.kind = EV_NOTE_OFF;
                    emit_evt.note = {1'b0, s_rkey};
                    idx_next = idx_reg + IXW'(1);
                end else begin
                    scnt_next  = '0;
                    state_next = S_OFF_ALL;
                end
            end
            S_OFF_ALL: begin
                emit_req = 1'b1;
                emit_evt.kind = EV_ALL_OFF;
                sn_next    = NO_NOTE;
                gr_next    = '0;
                state_next = S_FIN;
            end
            S_BUILD: begin
                if (boct_reg >= span_reg || act_cnt == '0
                        || plen_reg == LW'(MAX_PATTERN)) begin
                    state_next = ret_reg;
                end else begin
                    p_we = 1'b1;
                    p_wnote = (hold_reg ? {1'b0, lat_key_reg[bi_reg]} : {1'b0, h_rkey})
                              + boff_reg;
                    p_wvel  = hold_reg ? lat_vel_reg[bi_reg] : h_rvel;
                    plen_next = plen_reg + LW'(1);
                    if (HCW'(bi_reg) == act_cnt - HCW'(1)) begin
                        bi_next   = '0;
                        boct_next = boct_reg + 3'd1;
                        boff_next = boff_reg + OCT_STEP;
                    end else begin
                        bi_next = bi_reg + HIW'(1);
                    end
                end
            end
            S_LEN_MUL: begin
                prod_next  = 20'(base_reg) * 20'(swing_reg);
                state_next = S_LEN_DIV;
            end
            S_LEN_DIV: begin
                wide       = 42'(prod_reg) * 42'(SWING_RECIP);
                quo_next   = TW'(wide >> RECIP_SHIFT);
                state_next = S_LEN_FIN;
            end
            S_LEN_FIN: begin
                if (swing_reg == '0 || base_reg < 12'd2) begin
                    len_next = TW'(base_reg);
                end else begin
                    amt = (quo_reg >= TW'(base_reg)) ? base_reg - 12'd1 : quo_reg[11:0];
                    len_next = pos_reg[0] ? TW'(base_reg) + TW'(amt) : TW'(base_reg - amt);
                end
                state_next = ret_reg;
            end
            S_G_MUL: begin
                prod_next  = 20'(len_reg) * 20'(gate_reg);
                state_next = S_G_DIV;
            end
            S_G_DIV: begin
                wide       = 42'(prod_reg) * 42'(GATE_RECIP);
                quo_next   = TW'(wide >> RECIP_SHIFT);
                state_next = S_G_FIN;
            end
            S_G_FIN: begin
                g = quo_reg;
                if (g >= len_reg && len_reg != '0) begin
                    g = len_reg - TW'(1);
                end
                if (floor_reg && g == '0 && gate_reg != '0) begin
                    g = TW'(1);
                end
                gr_next    = g;
                state_next = S_NXT;
            end
            S_NXT: begin
                rem_next    = '0;
                modcnt_next = '0;
                state_next  = S_MOD;
                case (mode_reg)
                    MODE_UP:   divd_next = 16'(pos_reg) + 16'd1;
                    MODE_DOWN: divd_next = 16'(pos_reg) + 16'(plen_reg) - 16'd1;
                    MODE_PING: begin
                        state_next = S_FIN;
                        if (plen_reg == LW'(1)) begin
                            pos_next = '0;
                        end else if (!down_reg) begin
                            p1 = LW'(pos_reg) + LW'(1);
                            if (p1 >= plen_reg) begin
                                pos_next  = PW'(plen_reg - LW'(2));
                                down_next = 1'b1;
                            end else begin
                                pos_next = PW'(p1);
                            end
                        end else if (pos_reg == '0) begin
                            pos_next  = PW'(1);
                            down_next = 1'b0;
                        end else begin
                            p1 = LW'(pos_reg) - LW'(1);
                            if (p1 >= plen_reg) begin
                                pos_next = PW'(plen_reg - LW'(2));
                            end else begin
                                pos_next = PW'(p1);
                            end
                        end
                    end
                    default: begin
                        lf = lfsr_reg >> 1;
                        if (lfsr_reg[0]) begin
                            lf = lf ^ LFSR_TAPS;
                        end
                        lfsr_next = lf;
                        divd_next = lf;
                    end
                endcase
            end
            S_MOD: begin
                r2 = {rem_reg, divd_reg[15]};
                if (r2 >= (LW+1)'(plen_reg)) begin
                    r2 = r2 - (LW+1)'(plen_reg);
                end
                rem_next    = LW'(r2);
                divd_next   = divd_reg << 1;
                modcnt_next = modcnt_reg + 4'd1;
                if (modcnt_reg == 4'd15) begin
                    pos_next   = PW'(r2);
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                pend_vld_next = 1'b0;
                state_next    = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        if (emit_req) begin
            pend_next     = emit_evt;
            pend_vld_next = 1'b1;
        end
    end

    assign evt_push = go && pend_vld_reg && (emit_req || state_reg == S_FIN);
    always_comb begin
        evt      = pend_reg;
        evt.last = state_reg == S_FIN;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg    <= 1'b0;
            hold_reg  <= 1'b0;
            strum_reg <= 1'b0;
            mode_reg  <= 2'd0;
            span_reg  <= 3'd1;
            gate_reg  <= 7'd64;
            swing_reg <= 7'd0;
            base_reg  <= 12'd6;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ENABLED:   en_reg    <= cfg_data[0];
                REG_HOLD:      hold_reg  <= cfg_data[0];
                REG_STRUM:     strum_reg <= cfg_data[0];
                REG_PATTERN:   mode_reg  <= cfg_data[1:0];
                REG_OCTAVES:   span_reg  <= cfg_data[2:0];
                REG_GATE:      gate_reg  <= cfg_data[6:0];
                REG_SWING:     swing_reg <= cfg_data[6:0];
                REG_STEP_BASE: base_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_FIN;
            hcnt_reg     <= '0;
            lcnt_reg     <= '0;
            scnt_reg     <= '0;
            plen_reg     <= '0;
            pos_reg      <= '0;
            down_reg     <= 1'b0;
            ticks_reg    <= '0;
            gr_reg       <= '0;
            sn_reg       <= NO_NOTE;
            lfsr_reg     <= LFSR_SEED;
            pend_vld_reg <= 1'b0;
        end else if (go) begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            hcnt_reg     <= hcnt_next;
            lcnt_reg     <= lcnt_next;
            scnt_reg     <= scnt_next;
            plen_reg     <= plen_next;
            pos_reg      <= pos_next;
            down_reg     <= down_next;
            ticks_reg    <= ticks_next;
            gr_reg       <= gr_next;
            sn_reg       <= sn_next;
            lfsr_reg     <= lfsr_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            cmd_reg    <= cmd_next;
            idx_reg    <= idx_next;
            bi_reg     <= bi_next;
            boct_reg   <= boct_next;
            boff_reg   <= boff_next;
            len_reg    <= len_next;
            quo_reg    <= quo_next;
            prod_reg   <= prod_next;
            divd_reg   <= divd_next;
            floor_reg  <= floor_next;
            modcnt_reg <= modcnt_next;
            rem_reg    <= rem_next;
            pend_reg   <= pend_next;
            if (h_we) begin
                held_key_reg[h_waddr] <= h_wkey;
                held_vel_reg[h_waddr] <= h_wvel;
            end
            if (l_we) begin
                lat_key_reg[l_waddr] <= h_rkey;
                lat_vel_reg[l_waddr] <= h_rvel;
            end
            if (p_we) begin
                pat_note_reg[p_waddr] <= p_wnote;
                pat_vel_reg[p_waddr]  <= p_wvel;
            end
            if (s_we) begin
                strum_key_reg[s_waddr] <= cmd_reg.note;
            end
        end
    end

endmodule

### sv/midi_arpeggiator_sequencer_top.sv
// Channel   Direction  Ports                                   Contents
// s_        in         s_tvalid s_tready s_tdata s_tuser      one command item
// m_        out        m_tvalid m_tready m_tdata m_tuser m_tlast  one event item
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data register write
//
// An item is handled by the single sequencer of arp_back, which stalls whenever an event
// is pending and the output queue is full.
// The held list search, the latch copy and the pattern rebuild run one entry per cycle
// when not stalled; the random or wrapping step position comes from a remainder loop.
// Reset is synchronous and active low and leaves every list empty.
// A two-item queue on each side lets input and output stall on their own.
module midi_arpeggiator_sequencer_top import arp_pkg::*; #(
    parameter int MAX_HELD    = MAX_HELD_DEF,
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int MAX_STRUM   = MAX_STRUM_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // note_number, note_velocity
    input  logic [2:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // event_note, event_velocity
    output logic [1:0]  m_tuser,   // event_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    cmd_t cmd;
    logic cmd_valid, cmd_pop;
    evt_t evt, out_evt;
    logic evt_push, evt_full;
    logic [$bits(evt_t)-1:0] out_raw;

    arp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    arp_back #(
        .MAX_HELD    (MAX_HELD),
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_STRUM   (MAX_STRUM)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .evt_push  (evt_push),
        .evt       (evt),
        .evt_full  (evt_full)
    );

    arp_fifo #(.WIDTH($bits(evt_t))) u_evt_q (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (evt_push),
        .wdata    (evt),
        .full     (evt_full),
        .pop      (m_tvalid && m_tready),
        .rdata    (out_raw),
        .nonempty (m_tvalid)
    );

    assign out_evt = evt_t'(out_raw);
    assign m_tdata = {1'b0, out_evt.vel, out_evt.note};
    assign m_tuser = out_evt.kind;
    assign m_tlast = out_evt.last;

endmodule

### sv/arp_checker.sv
module arp_checker import arp_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [11:0] cfg_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    a_all_off_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_ALL_OFF |-> m_tlast)
        else $error("all-notes-off item is not the last of its command");

    a_off_no_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_NOTE_ON |-> m_tdata[14:8] == 7'd0)
        else $error("note-off item carries a velocity");

    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output item present right after reset");

endmodule

bind midi_arpeggiator_sequencer_top arp_checker u_arp_checker (.*);
